>>> hw/rtl/sbf_pkg.sv
package sbf_pkg;

    typedef enum logic [1:0] {
        KIND_PIXEL   = 2'd0,
        KIND_SPATIAL = 2'd1,
        KIND_RANGE   = 2'd2,
        KIND_FLUSH   = 2'd3
    } kind_t;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS       = 2'd2;

    localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd480;
    localparam logic [2:0]  RADIUS_RESET       = 3'd2;

    // Absolute difference of two gray levels.
    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        absdiff8 = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

>>> hw/rtl/sbf_ram.sv
module sbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/sbf_div.sv
module sbf_div #(
    parameter int NUM_W = 44,
    parameter int DEN_W = 36
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // One quotient bit per cycle, restoring form.
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

>>> hw/rtl/separable_bilateral_filter_core.sv
// Separable bilateral filter, one item at a time; in_stall stays high until the item is done.
// An emitting pixel may also wait on output stalls. The divider numerator is
// 2*WEIGHT_BITS + 8 + clog2(2*MAX_RADIUS+1) bits wide.
// An emitting flush runs only the horizontal pass; a table load does not raise in_stall.
// The first pixel or flush after a configuration write first recomputes the positions.
// Reset restores register defaults and clears positions and windows, not tables or rows.
module separable_bilateral_filter_core #(
    parameter int MAX_RADIUS  = 7,
    parameter int MAX_WIDTH   = 2048,
    parameter int MAX_HEIGHT  = 4096,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  pixel,
    input  logic [7:0]  table_index,
    input  logic [15:0] table_weight,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pixel_out,
    output logic        frame_end
);

    localparam int TAPS   = 2 * MAX_RADIUS + 1;
    localparam int K_W    = $clog2(TAPS);
    localparam int R_W    = $clog2(MAX_RADIUS + 1);
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int TOT_W  = POS_W + 1;
    localparam int SLOT_W = $clog2(2 * MAX_RADIUS);
    localparam int SW2    = SLOT_W + 2;
    localparam int DEPTH  = 2 * MAX_RADIUS * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = 2 * WEIGHT_BITS;
    localparam int NUM_W  = PROD_W + 8 + K_W;
    localparam int DEN_W  = PROD_W + K_W;

    typedef enum logic [4:0] {
        S_IDLE, S_SYNC0, S_SYNC1, S_SYNC2, S_SYNC3, S_SYNC4, S_SYNC5,
        S_DISPATCH, S_CEN_RD, S_CEN_CAP, S_VCHK,
        S_TAP_RD, S_TAP_RW, S_TAP_MUL, S_TAP_ACC,
        S_SUM_DONE, S_DIV_WAIT, S_DIV_DONE,
        S_WRITE, S_EMIT_CHK, S_EMIT_OUT
    } state_t;

    state_t state_reg, ret_reg;

    logic [11:0] fw_reg;
    logic [12:0] fh_reg;
    logic [2:0]  rad_reg;
    logic        resync_reg;

    sbf_pkg::kind_t kind_reg;
    logic [7:0]     pixel_reg;

    logic [POS_W-1:0]  in_pos_reg, out_pos_reg;
    logic [H_W-1:0]    y_reg, oi_reg;
    logic [W_W-1:0]    x_reg, oj_reg;
    logic [SLOT_W-1:0] ys_reg;
    logic [TOT_W-1:0]  pend_reg;

    logic [7:0]             centre_reg, val_reg, res_reg;
    logic [WEIGHT_BITS-1:0] sw_sel_reg;
    logic [PROD_W-1:0]      wt_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [K_W-1:0]         k_reg;
    logic                   hmode_reg;

    logic [7:0]             vwin_reg [TAPS];
    logic [7:0]             cwin_reg [TAPS];
    logic [WEIGHT_BITS-1:0] sw_tab_reg [TAPS];

    logic       out_valid_reg;
    logic [7:0] pixel_out_reg;
    logic       frame_end_reg;

    // Effective frame geometry.
    logic [W_W-1:0]   w_eff;
    logic [H_W-1:0]   h_eff;
    logic [R_W-1:0]   r_eff;
    logic [TOT_W-1:0] total;
    logic [TOT_W-1:0] lag;
    logic [SW2-1:0]   two_r;
    logic [K_W-1:0]   two_r_k;

    always_comb
    begin
        if (fw_reg == '0)
            w_eff = W_W'(1);
        else if (32'(fw_reg) > MAX_WIDTH)
            w_eff = W_W'(MAX_WIDTH);
        else
            w_eff = W_W'(fw_reg);
        if (fh_reg == '0)
            h_eff = H_W'(1);
        else if (32'(fh_reg) > MAX_HEIGHT)
            h_eff = H_W'(MAX_HEIGHT);
        else
            h_eff = H_W'(fh_reg);
        if (32'(rad_reg) > MAX_RADIUS)
            r_eff = R_W'(MAX_RADIUS);
        else
            r_eff = R_W'(rad_reg);
    end

    assign total   = TOT_W'(TOT_W'(w_eff) * TOT_W'(h_eff));
    assign lag     = TOT_W'(TOT_W'(r_eff) * TOT_W'(w_eff) + TOT_W'(r_eff));
    assign two_r   = SW2'({r_eff, 1'b0});
    assign two_r_k = K_W'({r_eff, 1'b0});

    logic in_accept;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Row-store slots: the centre row and the tap rows of the current column.
    logic [SW2-1:0]    tslot_sum, cslot_w, tslot_w;
    logic [SLOT_W-1:0] rd_slot;

    always_comb
    begin
        tslot_sum = SW2'(ys_reg) + SW2'(k_reg);
        tslot_w   = (tslot_sum >= two_r) ? (tslot_sum - two_r) : tslot_sum;
        if (SW2'(ys_reg) >= SW2'(r_eff))
            cslot_w = SW2'(ys_reg) - SW2'(r_eff);
        else
            cslot_w = SW2'(ys_reg) + SW2'(r_eff);
        rd_slot = (state_reg == S_CEN_RD) ? SLOT_W'(cslot_w) : SLOT_W'(tslot_w);
    end

    logic [ADDR_W-1:0] row_raddr, row_waddr;
    logic [7:0]        row_rdata;
    logic              row_we;

    assign row_raddr = ADDR_W'(32'(rd_slot) * MAX_WIDTH + 32'(x_reg));
    assign row_waddr = ADDR_W'(32'(ys_reg) * MAX_WIDTH + 32'(x_reg));
    assign row_we    = (state_reg == S_WRITE) && (r_eff != '0);

    sbf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_row_store (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (pixel_reg),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    // Tap operands for both passes.
    logic [K_W-1:0] hbase, hidx, hcen;
    logic [7:0]     p_sel, d_sel, c_sel;

    always_comb
    begin
        hbase = K_W'(TAPS - 1) - two_r_k;
        hidx  = hbase + k_reg;
        hcen  = hbase + K_W'(r_eff);
        if (hmode_reg)
        begin
            p_sel = vwin_reg[hidx];
            d_sel = cwin_reg[hidx];
            c_sel = cwin_reg[hcen];
        end
        else
        begin
            p_sel = (k_reg == two_r_k) ? pixel_reg : row_rdata;
            d_sel = p_sel;
            c_sel = centre_reg;
        end
    end

    logic [WEIGHT_BITS-1:0] rw_rdata;
    logic                   rw_we;

    assign rw_we = in_accept && (kind == sbf_pkg::KIND_RANGE);

    sbf_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (256)
    ) u_range_table (
        .clk   (clk),
        .we    (rw_we),
        .waddr (table_index),
        .wdata (WEIGHT_BITS'(table_weight)),
        .raddr (sbf_pkg::absdiff8(c_sel, d_sel)),
        .rdata (rw_rdata)
    );

    // Shared divider: position split and pass quotients.
    logic [POS_W-1:0] in_pos_wrap, out_pos_wrap;
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den, div_rem;

    assign in_pos_wrap  = (TOT_W'(in_pos_reg) >= total) ? '0 : in_pos_reg;
    assign out_pos_wrap = (TOT_W'(out_pos_reg) >= total) ? '0 : out_pos_reg;

    always_comb
    begin
        div_start = 1'b0;
        div_num   = num_reg;
        div_den   = den_reg;
        unique case (state_reg)
            S_SYNC0:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'(in_pos_wrap);
                div_den   = DEN_W'(w_eff);
            end
            S_SYNC2:
            begin
                div_start = (r_eff != '0);
                div_num   = NUM_W'(y_reg);
                div_den   = DEN_W'(two_r);
            end
            S_SYNC4:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'(out_pos_reg);
                div_den   = DEN_W'(w_eff);
            end
            S_SUM_DONE:
            begin
                div_start = (den_reg != '0);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    sbf_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    logic [PROD_W+7:0] tap_prod;
    logic              v_inside, h_inside;

    assign tap_prod = (PROD_W + 8)'(wt_reg) * (PROD_W + 8)'(val_reg);
    assign v_inside = (32'(y_reg) >= 32'(two_r)) && (32'(x_reg) >= 32'(r_eff))
                      && (32'(x_reg) + 32'(r_eff) < 32'(w_eff));
    assign h_inside = (32'(oi_reg) >= 32'(r_eff)) && (32'(oi_reg) + 32'(r_eff) < 32'(h_eff))
                      && (32'(oj_reg) >= 32'(r_eff)) && (32'(oj_reg) + 32'(r_eff) < 32'(w_eff));

    always_ff @(posedge clk)
    begin
        if (in_accept && (kind == sbf_pkg::KIND_SPATIAL) && (32'(table_index) < TAPS))
        begin
            sw_tab_reg[K_W'(table_index)] <= WEIGHT_BITS'(table_weight);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            fw_reg        <= sbf_pkg::FRAME_WIDTH_RESET;
            fh_reg        <= sbf_pkg::FRAME_HEIGHT_RESET;
            rad_reg       <= sbf_pkg::RADIUS_RESET;
            resync_reg    <= 1'b0;
            kind_reg      <= sbf_pkg::KIND_PIXEL;
            in_pos_reg    <= '0;
            out_pos_reg   <= '0;
            y_reg         <= '0;
            x_reg         <= '0;
            ys_reg        <= '0;
            oi_reg        <= '0;
            oj_reg        <= '0;
            pend_reg      <= '0;
            k_reg         <= '0;
            hmode_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TAPS; i++)
            begin
                vwin_reg[i] <= '0;
                cwin_reg[i] <= '0;
            end
        end
        else
        begin
            // In S_EMIT_OUT the output register is handled by that state alone.
            if (out_valid_reg && !out_stall && (state_reg != S_EMIT_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    sbf_pkg::CFG_FRAME_WIDTH:  fw_reg  <= cfg_data[11:0];
                    sbf_pkg::CFG_FRAME_HEIGHT: fh_reg  <= cfg_data;
                    sbf_pkg::CFG_RADIUS:       rad_reg <= cfg_data[2:0];
                    default:                   fw_reg  <= fw_reg;
                endcase
                resync_reg <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        kind_reg  <= sbf_pkg::kind_t'(kind);
                        pixel_reg <= pixel;
                        if ((kind == sbf_pkg::KIND_PIXEL) || (kind == sbf_pkg::KIND_FLUSH))
                        begin
                            state_reg <= resync_reg ? S_SYNC0 : S_DISPATCH;
                        end
                    end
                end
                S_SYNC0:
                begin
                    in_pos_reg  <= in_pos_wrap;
                    out_pos_reg <= out_pos_wrap;
                    ret_reg     <= S_SYNC1;
                    state_reg   <= S_DIV_WAIT;
                end
                S_SYNC1:
                begin
                    y_reg     <= H_W'(div_quo);
                    x_reg     <= W_W'(div_rem);
                    state_reg <= S_SYNC2;
                end
                S_SYNC2:
                begin
                    if (r_eff != '0)
                    begin
                        ret_reg   <= S_SYNC3;
                        state_reg <= S_DIV_WAIT;
                    end
                    else
                    begin
                        ys_reg    <= '0;
                        state_reg <= S_SYNC4;
                    end
                end
                S_SYNC3:
                begin
                    ys_reg    <= SLOT_W'(div_rem);
                    state_reg <= S_SYNC4;
                end
                S_SYNC4:
                begin
                    ret_reg   <= S_SYNC5;
                    state_reg <= S_DIV_WAIT;
                end
                S_SYNC5:
                begin
                    oi_reg     <= H_W'(div_quo);
                    oj_reg     <= W_W'(div_rem);
                    resync_reg <= 1'b0;
                    state_reg  <= S_DISPATCH;
                end
                S_DISPATCH:
                begin
                    if (kind_reg == sbf_pkg::KIND_FLUSH)
                    begin
                        state_reg <= ((pend_reg != '0) && (in_pos_reg == '0)) ? S_EMIT_CHK
                                                                                : S_IDLE;
                    end
                    else if (32'(y_reg) >= 32'(r_eff))
                    begin
                        if (r_eff != '0)
                        begin
                            state_reg <= S_CEN_RD;
                        end
                        else
                        begin
                            centre_reg <= pixel_reg;
                            state_reg  <= S_VCHK;
                        end
                    end
                    else
                    begin
                        centre_reg <= '0;
                        state_reg  <= S_VCHK;
                    end
                end
                S_CEN_RD:
                begin
                    state_reg <= S_CEN_CAP;
                end
                S_CEN_CAP:
                begin
                    centre_reg <= row_rdata;
                    state_reg  <= S_VCHK;
                end
                S_VCHK:
                begin
                    if (v_inside)
                    begin
                        hmode_reg <= 1'b0;
                        k_reg     <= '0;
                        num_reg   <= '0;
                        den_reg   <= '0;
                        state_reg <= S_TAP_RD;
                    end
                    else
                    begin
                        res_reg   <= '0;
                        state_reg <= S_WRITE;
                    end
                end
                S_TAP_RD:
                begin
                    state_reg <= S_TAP_RW;
                end
                S_TAP_RW:
                begin
                    val_reg    <= p_sel;
                    sw_sel_reg <= sw_tab_reg[k_reg];
                    state_reg  <= S_TAP_MUL;
                end
                S_TAP_MUL:
                begin
                    wt_reg    <= PROD_W'(PROD_W'(sw_sel_reg) * PROD_W'(rw_rdata));
                    state_reg <= S_TAP_ACC;
                end
                S_TAP_ACC:
                begin
                    num_reg <= num_reg + NUM_W'(tap_prod);
                    den_reg <= den_reg + DEN_W'(wt_reg);
                    if (k_reg == two_r_k)
                    begin
                        state_reg <= S_SUM_DONE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_TAP_RD;
                    end
                end
                S_SUM_DONE:
                begin
                    if (den_reg != '0)
                    begin
                        ret_reg   <= S_DIV_DONE;
                        state_reg <= S_DIV_WAIT;
                    end
                    else
                    begin
                        res_reg   <= '0;
                        state_reg <= hmode_reg ? S_EMIT_OUT : S_WRITE;
                    end
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ret_reg;
                    end
                end
                S_DIV_DONE:
                begin
                    res_reg   <= div_quo[7:0];
                    state_reg <= hmode_reg ? S_EMIT_OUT : S_WRITE;
                end
                S_WRITE:
                begin
                    for (int i = 0; i < TAPS - 1; i++)
                    begin
                        vwin_reg[i] <= vwin_reg[i+1];
                        cwin_reg[i] <= cwin_reg[i+1];
                    end
                    vwin_reg[TAPS-1] <= res_reg;
                    cwin_reg[TAPS-1] <= centre_reg;
                    if (TOT_W'(in_pos_reg) + 1'b1 == total)
                    begin
                        in_pos_reg <= '0;
                        x_reg      <= '0;
                        y_reg      <= '0;
                        ys_reg     <= '0;
                    end
                    else
                    begin
                        in_pos_reg <= in_pos_reg + 1'b1;
                        if (32'(x_reg) + 1 == 32'(w_eff))
                        begin
                            x_reg  <= '0;
                            y_reg  <= y_reg + 1'b1;
                            ys_reg <= (SW2'(ys_reg) + 1'b1 == two_r) ? '0 : ys_reg + 1'b1;
                        end
                        else
                        begin
                            x_reg <= x_reg + 1'b1;
                        end
                    end
                    pend_reg  <= pend_reg + 1'b1;
                    state_reg <= (pend_reg + 1'b1 > lag) ? S_EMIT_CHK : S_IDLE;
                end
                S_EMIT_CHK:
                begin
                    if (h_inside)
                    begin
                        hmode_reg <= 1'b1;
                        k_reg     <= '0;
                        num_reg   <= '0;
                        den_reg   <= '0;
                        state_reg <= S_TAP_RD;
                    end
                    else
                    begin
                        res_reg   <= '0;
                        state_reg <= S_EMIT_OUT;
                    end
                end
                S_EMIT_OUT:
                begin
                    // The held beat must leave before a new one is loaded.
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        pixel_out_reg <= res_reg;
                        frame_end_reg <= (TOT_W'(out_pos_reg) + 1'b1 == total);
                        if (TOT_W'(out_pos_reg) + 1'b1 == total)
                        begin
                            out_pos_reg <= '0;
                            oi_reg      <= '0;
                            oj_reg      <= '0;
                        end
                        else
                        begin
                            out_pos_reg <= out_pos_reg + 1'b1;
                            if (32'(oj_reg) + 1 == 32'(w_eff))
                            begin
                                oj_reg <= '0;
                                oi_reg <= oi_reg + 1'b1;
                            end
                            else
                            begin
                                oj_reg <= oj_reg + 1'b1;
                            end
                        end
                        pend_reg  <= pend_reg - 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign frame_end = frame_end_reg;

    a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_OUT) |-> (pend_reg != '0))
        else $error("result emitted with no pending pixel");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside a wait state");

    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAP_ACC) |-> (k_reg <= two_r_k))
        else $error("tap index beyond window");

    a_in_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        !resync_reg |-> (TOT_W'(in_pos_reg) < total))
        else $error("input position beyond frame");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("result dropped while stalled");

endmodule

>>> tb/sv/separable_bilateral_filter_core_tb.sv
module separable_bilateral_filter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS        = 15;
    localparam int LINE_WIDTH  = 2048;
    localparam int LINE_DEPTH  = 14 * LINE_WIDTH;
    localparam int IDLE_CYCLES = 400;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       frame_end;
    } filtered_beat_t;

    logic           clk;
    logic           rst_n;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [1:0]     cfg_index;
    logic [12:0]    cfg_data;
    logic           in_valid;
    logic           in_stall;
    sbf_pkg::kind_t kind;
    logic [7:0]     pixel;
    logic [7:0]     table_index;
    logic [15:0]    table_weight;
    logic           out_valid;
    logic           out_stall = 1'b0;
    logic [7:0]     pixel_out;
    logic           frame_end;

    // Shadow copy of the filter state.
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  radius_reg;
    logic [7:0]  line_mem [LINE_DEPTH];
    logic [7:0]  vert_win [TAPS];
    logic [7:0]  ctr_win [TAPS];
    logic [15:0] spatial_tab [TAPS];
    logic [15:0] range_tab [256];
    int unsigned in_pos;
    int unsigned out_pos;
    int unsigned pending_px;

    filtered_beat_t filtered_q[$];
    int unsigned    mismatch_count;
    int unsigned    burst_left;
    int unsigned    pixels_sent;
    int unsigned    items_sent;
    int unsigned    stall_mode;
    int unsigned    stall_age;

    separable_bilateral_filter_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .pixel        (pixel),
        .table_index  (table_index),
        .table_weight (table_weight),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_out    (pixel_out),
        .frame_end    (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned gray_dist(logic [7:0] a, logic [7:0] b);
        return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    function automatic void frame_dims(output int unsigned w, output int unsigned h,
                                       output int unsigned r);
        w = (width_reg == 0) ? 1 : ((width_reg > LINE_WIDTH) ? LINE_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : ((height_reg > 4096) ? 4096 : height_reg);
        r = radius_reg;
    endfunction

    function automatic void emit_filtered(int unsigned w, int unsigned h, int unsigned r,
                                          int unsigned total);
        int unsigned       row;
        int unsigned       col;
        int unsigned       base;
        logic [7:0]        c;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   wt;
        filtered_beat_t    beat;
        row = out_pos / w;
        col = out_pos % w;
        beat.pixel_out = 8'd0;
        if (row >= r && row + r < h && col >= r && col + r < w)
        begin
            base = 14 - 2 * r;
            c = ctr_win[base + r];
            num = 0;
            den = 0;
            for (int k = 0; k <= 2 * r; k++)
            begin
                wt = longint'(spatial_tab[k]) * range_tab[gray_dist(c, ctr_win[base + k])];
                num += wt * vert_win[base + k];
                den += wt;
            end
            beat.pixel_out = (den != 0) ? 8'(num / den) : 8'd0;
        end
        beat.frame_end = (out_pos == total - 1);
        filtered_q = {filtered_q, beat};
        pending_px--;
        out_pos++;
        if (out_pos >= total)
            out_pos = 0;
    endfunction

    // Advances the shadow state by one accepted input beat.
    function automatic void predict_filter(sbf_pkg::kind_t k, logic [7:0] px, logic [7:0] idx,
                                           logic [15:0] wgt);
        int unsigned     w;
        int unsigned     h;
        int unsigned     r;
        int unsigned     total;
        int unsigned     y;
        int unsigned     x;
        logic [7:0]      centre;
        logic [7:0]      v;
        logic [7:0]      p;
        longint unsigned num;
        longint unsigned den;
        longint unsigned wt;
        if (k == sbf_pkg::KIND_SPATIAL)
        begin
            if (idx < TAPS)
                spatial_tab[idx] = wgt;
            return;
        end
        if (k == sbf_pkg::KIND_RANGE)
        begin
            range_tab[idx] = wgt;
            return;
        end
        frame_dims(w, h, r);
        total = w * h;
        if (in_pos >= total)
            in_pos = 0;
        if (out_pos >= total)
            out_pos = 0;
        if (k == sbf_pkg::KIND_FLUSH)
        begin
            if (pending_px != 0 && in_pos == 0)
                emit_filtered(w, h, r, total);
            return;
        end
        y = in_pos / w;
        x = in_pos % w;
        centre = 8'd0;
        v = 8'd0;
        if (y >= r)
            centre = (r != 0) ? line_mem[((y - r) % (2 * r)) * LINE_WIDTH + x] : px;
        if (y >= 2 * r && x >= r && x + r < w)
        begin
            num = 0;
            den = 0;
            for (int t = 0; t <= 2 * r; t++)
            begin
                p = (t == 2 * r) ? px : line_mem[((y - 2 * r + t) % (2 * r)) * LINE_WIDTH + x];
                wt = longint'(spatial_tab[t]) * range_tab[gray_dist(centre, p)];
                num += wt * p;
                den += wt;
            end
            v = (den != 0) ? 8'(num / den) : 8'd0;
        end
        if (r != 0)
            line_mem[(y % (2 * r)) * LINE_WIDTH + x] = px;
        for (int t = 0; t < TAPS - 1; t++)
        begin
            vert_win[t] = vert_win[t + 1];
            ctr_win[t] = ctr_win[t + 1];
        end
        vert_win[TAPS - 1] = v;
        ctr_win[TAPS - 1] = centre;
        in_pos++;
        if (in_pos >= total)
            in_pos = 0;
        pending_px++;
        if (pending_px > r * w + r)
            emit_filtered(w, h, r, total);
    endfunction

    task automatic send_item(sbf_pkg::kind_t k, logic [7:0] px, logic [7:0] idx,
                             logic [15:0] wgt);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        pixel        <= px;
        table_index  <= idx;
        table_weight <= wgt;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        items_sent++;
        if (k == sbf_pkg::KIND_PIXEL)
            pixels_sent++;
        predict_filter(k, px, idx, wgt);
    endtask

    // Drops valid and waits until every expected beat has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (filtered_q.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == sbf_pkg::CFG_FRAME_WIDTH)
            width_reg = value[11:0];
        else if (idx == sbf_pkg::CFG_FRAME_HEIGHT)
            height_reg = value;
        else if (idx == sbf_pkg::CFG_RADIUS)
            radius_reg = value[2:0];
    endtask

    task automatic set_frame(logic [12:0] w, logic [12:0] h, logic [12:0] r);
        wait_idle();
        write_reg(sbf_pkg::CFG_FRAME_WIDTH, w);
        write_reg(sbf_pkg::CFG_FRAME_HEIGHT, h);
        write_reg(sbf_pkg::CFG_RADIUS, r);
        cfg_valid <= 1'b0;
    endtask

    // Sends one full frame, then flushes until the tail has drained.
    task automatic run_frame(int unsigned style);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        logic [7:0]  base;
        logic [7:0]  px;
        frame_dims(w, h, r);
        base = $urandom_range(0, 255);
        for (int n = 0; n < w * h; n++)
        begin
            case (style)
                0: px = $urandom_range(0, 255);
                1: px = base + 8'($urandom_range(0, 12));
                default: px = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            endcase
            send_item(sbf_pkg::KIND_PIXEL, px, 8'($urandom), 16'($urandom));
            // A flush in mid frame is ignored.
            if ($urandom_range(0, 30) == 0)
                send_item(sbf_pkg::KIND_FLUSH, 8'($urandom), 8'($urandom), 16'($urandom));
        end
        while (pending_px != 0)
            send_item(sbf_pkg::KIND_FLUSH, 8'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic test_table_load();
        for (int i = 0; i < 256; i++)
            send_item(sbf_pkg::KIND_RANGE, 8'($urandom), i[7:0],
                      (i == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535)));
        for (int i = 0; i < TAPS; i++)
            send_item(sbf_pkg::KIND_SPATIAL, 8'($urandom), i[7:0],
                      16'($urandom_range(1, 65535)));
        // Spatial indexes past the window are dropped.
        send_item(sbf_pkg::KIND_SPATIAL, 8'd0, 8'd15, 16'd0);
        send_item(sbf_pkg::KIND_SPATIAL, 8'd0, 8'd255, 16'd0);
    endtask

    task automatic test_single_pixel_frame();
        set_frame(13'd0, 13'd0, 13'd0);
        send_item(sbf_pkg::KIND_FLUSH, 8'd0, 8'd0, 16'd0);
        send_item(sbf_pkg::KIND_PIXEL, 8'd0, 8'd0, 16'd0);
        send_item(sbf_pkg::KIND_PIXEL, 8'd255, 8'd255, 16'hFFFF);
        send_item(sbf_pkg::KIND_PIXEL, 8'h5A, 8'hA5, 16'h5A5A);
        send_item(sbf_pkg::KIND_FLUSH, 8'd0, 8'd0, 16'd0);
    endtask

    task automatic test_zero_weight_sum();
        logic [15:0] saved [3];
        set_frame(13'd5, 13'd5, 13'd1);
        for (int i = 0; i < 3; i++)
        begin
            saved[i] = spatial_tab[i];
            send_item(sbf_pkg::KIND_SPATIAL, 8'd0, i[7:0], 16'd0);
        end
        run_frame(2);
        for (int i = 0; i < 3; i++)
            send_item(sbf_pkg::KIND_SPATIAL, 8'd0, i[7:0], saved[i]);
    endtask

    task automatic test_largest_radius();
        set_frame(13'd15, 13'd15, 13'd7);
        run_frame(1);
        // A frame smaller than the window gives only border zeros.
        set_frame(13'd8, 13'd3, 13'd7);
        run_frame(0);
    endtask

    task automatic test_random_frames();
        while (items_sent < 780)
        begin
            set_frame(13'($urandom_range(1, 12)), 13'($urandom_range(1, 10)),
                      13'($urandom_range(0, 7)));
            repeat ($urandom_range(0, 6))
                send_item(sbf_pkg::KIND_RANGE, 8'($urandom), 8'($urandom),
                          $urandom_range(0, 9) ? 16'($urandom) : 16'd0);
            if ($urandom_range(0, 3) == 0)
                send_item(sbf_pkg::KIND_SPATIAL, 8'($urandom), 8'($urandom_range(0, 20)),
                          16'($urandom));
            run_frame($urandom_range(0, 2));
        end
    endtask

    // Register values above the supported sizes; only the head of the frame is sent.
    task automatic test_oversize_frame();
        set_frame(13'd4095, 13'd8191, 13'd7);
        repeat (30)
            send_item(sbf_pkg::KIND_PIXEL, 8'($urandom), 8'($urandom), 16'($urandom));
    endtask

    always @(posedge clk)
    begin
        if (stall_age == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_age = $urandom_range(50, 400);
        end
        stall_age--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        filtered_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (filtered_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: pixel_out=%0d frame_end=%0b",
                             pixel_out, frame_end);
            end
            else
            begin
                want = filtered_q.pop_front();
                if (pixel_out !== want.pixel_out || frame_end !== want.frame_end)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("beat mismatch: expected %0d/%0b, got %0d/%0b",
                                 want.pixel_out, want.frame_end, pixel_out, frame_end);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = sbf_pkg::CFG_FRAME_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = sbf_pkg::KIND_PIXEL;
        pixel = '0;
        table_index = '0;
        table_weight = '0;
        width_reg = sbf_pkg::FRAME_WIDTH_RESET;
        height_reg = sbf_pkg::FRAME_HEIGHT_RESET;
        radius_reg = sbf_pkg::RADIUS_RESET;
        foreach (line_mem[i])
            line_mem[i] = 8'd0;
        foreach (vert_win[i])
        begin
            vert_win[i] = 8'd0;
            ctr_win[i] = 8'd0;
            spatial_tab[i] = 16'd0;
        end
        foreach (range_tab[i])
            range_tab[i] = 16'd0;
        in_pos = 0;
        out_pos = 0;
        pending_px = 0;
        mismatch_count = 0;
        burst_left = 0;
        pixels_sent = 0;
        items_sent = 0;
        stall_mode = 0;
        stall_age = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_single_pixel_frame();
        test_zero_weight_sum();
        test_largest_radius();
        test_random_frames();
        test_oversize_frame();
        wait_idle();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
